// ----- src/hrbp_pkg.sv -----
// Package with the state, tag and status codes and the character classes of the request parser.
package hrbp_pkg;

   typedef enum logic [4:0] {
      ST_INVALID       = 5'd0,
      ST_START         = 5'd1,
      ST_METHOD        = 5'd2,
      ST_BEFORE_URI    = 5'd3,
      ST_IN_URI        = 5'd4,
      ST_BEFORE_QKEY   = 5'd5,
      ST_QKEY          = 5'd6,
      ST_BEFORE_QVAL   = 5'd7,
      ST_QVAL          = 5'd8,
      ST_BEFORE_PROTO  = 5'd9,
      ST_PROTO         = 5'd10,
      ST_BEFORE_VER    = 5'd11,
      ST_VER_DOT       = 5'd12,
      ST_VER           = 5'd13,
      ST_HKEY          = 5'd14,
      ST_BEFORE_COLON  = 5'd15,
      ST_AFTER_COLON   = 5'd16,
      ST_HVAL          = 5'd17,
      ST_CR            = 5'd18,
      ST_CRLF          = 5'd19,
      ST_CRLFCR        = 5'd20,
      ST_BODY          = 5'd21,
      ST_COMPLETE      = 5'd22
   } parse_state_type;

   typedef logic [3:0] field_tag_type;
   typedef logic [1:0] commit_type;
   typedef logic [1:0] status_type;
   typedef logic [1:0] num_phase_type;

   localparam field_tag_type TAG_NONE      = 4'd0;
   localparam field_tag_type TAG_METHOD    = 4'd1;
   localparam field_tag_type TAG_PATH      = 4'd2;
   localparam field_tag_type TAG_QKEY      = 4'd3;
   localparam field_tag_type TAG_QVAL      = 4'd4;
   localparam field_tag_type TAG_PROTO     = 4'd5;
   localparam field_tag_type TAG_VERSION   = 4'd6;
   localparam field_tag_type TAG_HKEY      = 4'd7;
   localparam field_tag_type TAG_HVAL      = 4'd8;
   localparam field_tag_type TAG_BODY      = 4'd9;

   localparam commit_type COMMIT_NONE      = 2'd0;
   localparam commit_type COMMIT_QUERY     = 2'd1;
   localparam commit_type COMMIT_HEADER    = 2'd2;

   localparam status_type STATUS_PARSING   = 2'd0;
   localparam status_type STATUS_COMPLETE  = 2'd1;
   localparam status_type STATUS_INVALID   = 2'd2;

   localparam num_phase_type NUM_SKIP      = 2'd0;
   localparam num_phase_type NUM_SIGN      = 2'd1;
   localparam num_phase_type NUM_DIGITS    = 2'd2;
   localparam num_phase_type NUM_DONE      = 2'd3;

   localparam logic [7:0] CH_QUESTION = 8'h3F;
   localparam logic [7:0] CH_EQUALS   = 8'h3D;
   localparam logic [7:0] CH_AMP      = 8'h26;
   localparam logic [7:0] CH_SLASH    = 8'h2F;
   localparam logic [7:0] CH_COLON    = 8'h3A;
   localparam logic [7:0] CH_DOT      = 8'h2E;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_PLUS     = 8'h2B;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_ZERO     = 8'h30;

   localparam logic [3:0] KEY_LEN = 4'd14;

   // Characters of the literal Content-Length, by position.
   function automatic logic [7:0] key_char(input logic [3:0] pos);
      logic [7:0] ch;
      unique case (pos)
         4'd0:    ch = 8'h43;
         4'd1:    ch = 8'h6F;
         4'd2:    ch = 8'h6E;
         4'd3:    ch = 8'h74;
         4'd4:    ch = 8'h65;
         4'd5:    ch = 8'h6E;
         4'd6:    ch = 8'h74;
         4'd7:    ch = 8'h2D;
         4'd8:    ch = 8'h4C;
         4'd9:    ch = 8'h65;
         4'd10:   ch = 8'h6E;
         4'd11:   ch = 8'h67;
         4'd12:   ch = 8'h74;
         4'd13:   ch = 8'h68;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB);
   endfunction

   function automatic logic is_upper(input logic [7:0] c);
      return (c >= 8'h41) && (c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

endpackage

// ----- src/hrbp_req_if.sv -----
// Interface of the request byte channel.
interface hrbp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_new;

   modport source (output valid, output data_byte, output start_new, input ready);
   modport sink   (input valid, input data_byte, input start_new, output ready);
endinterface

// ----- src/hrbp_rsp_if.sv -----
// Interface of the tagged result channel.
interface hrbp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  echo_byte;
   logic [3:0]  field_tag;
   logic        field_first;
   logic [1:0]  pair_commit;
   logic [1:0]  parse_status;
   logic        byte_ignored;
   logic [31:0] body_length;

   modport source (output valid, output echo_byte, output field_tag, output field_first,
                   output pair_commit, output parse_status, output byte_ignored,
                   output body_length, input ready);
   modport sink   (input valid, input echo_byte, input field_tag, input field_first,
                   input pair_commit, input parse_status, input byte_ignored,
                   input body_length, output ready);
endinterface

// ----- src/http_request_byte_parser.sv -----
// Top level of the byte-wise HTTP request parser with its input and result registers.
// A transaction taken into the input register is parsed there; its result is loaded into the
// result register and offered from it. Throughput: one byte per cycle unless a result waits;
// the parse state is registered together with the result of each byte.
// Reset: synchronous, clears the parse state to the start of a request line and empties
// both registers; start_new on a transaction clears the parse state before that byte.
module http_request_byte_parser #(
   parameter int LENGTH_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   hrbp_req_if.sink          req_ch,
   hrbp_rsp_if.source        rsp_ch
);
   import hrbp_pkg::*;

   localparam int LW = LENGTH_WIDTH;
   localparam logic [LW-1:0] LEN_MASK = {LW{1'b1}};

   logic                  in_valid_ff;
   logic [7:0]            in_byte_ff;
   logic                  in_start_ff;

   parse_state_type       state_ff, state_in;
   logic [3:0]            key_pos_ff, key_pos_in;
   logic                  key_match_ff, key_match_in;
   logic                  len_seen_ff, len_seen_in;
   num_phase_type         num_phase_ff, num_phase_in;
   logic                  num_neg_ff, num_neg_in;
   logic [LW-1:0]         num_acc_ff, num_acc_in;
   logic [LW-1:0]         len_value_ff, len_value_in;
   logic [LW-1:0]         body_count_ff, body_count_in;

   logic                  rsp_valid_ff;
   logic [7:0]            rsp_byte_ff;
   field_tag_type         rsp_tag_ff, rsp_tag_in;
   logic                  rsp_first_ff, rsp_first_in;
   commit_type            rsp_commit_ff, rsp_commit_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic                  rsp_ignored_ff, rsp_ignored_in;

   logic                  advance;
   logic [LW+31:0]        len_ext;

   // Parse state as seen by the byte, after an optional clear.
   parse_state_type       st;
   logic [3:0]            kpos;
   logic                  kmatch;
   logic                  lseen;
   num_phase_type         nphase;
   logic                  nneg;
   logic [LW-1:0]         nacc;
   logic [LW-1:0]         lval;
   logic [LW-1:0]         bcount;

   logic [3:0]            kf_pos_src;
   logic                  kf_match_src;
   logic [3:0]            kf_pos;
   logic                  kf_match;

   num_phase_type         nf_phase_src;
   logic                  nf_neg_src;
   logic [LW-1:0]         nf_acc_src;
   num_phase_type         nf_phase;
   logic                  nf_neg;
   logic [LW-1:0]         nf_acc;
   logic [LW+3:0]         nf_wide;
   logic [LW-1:0]         body_count_inc;
   logic [7:0]            c;

   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !in_valid_ff || advance;
   assign c             = in_byte_ff;

   always_comb begin
      st     = in_start_ff ? ST_START : state_ff;
      kpos   = in_start_ff ? 4'd0 : key_pos_ff;
      kmatch = in_start_ff ? 1'b0 : key_match_ff;
      lseen  = in_start_ff ? 1'b0 : len_seen_ff;
      nphase = in_start_ff ? NUM_SKIP : num_phase_ff;
      nneg   = in_start_ff ? 1'b0 : num_neg_ff;
      nacc   = in_start_ff ? '0 : num_acc_ff;
      lval   = in_start_ff ? '0 : len_value_ff;
      bcount = in_start_ff ? '0 : body_count_ff;
   end

   // Running match of the header key; a new key line starts it afresh.
   always_comb begin
      kf_pos_src   = (st == ST_CRLF) ? 4'd0 : kpos;
      kf_match_src = (st == ST_CRLF) ? 1'b1 : kmatch;
      if (kf_match_src && (kf_pos_src < KEY_LEN) && (c == key_char(kf_pos_src))) begin
         kf_pos   = kf_pos_src + 4'd1;
         kf_match = kf_match_src;
      end else begin
         kf_pos   = kf_pos_src;
         kf_match = 1'b0;
      end
   end

   // Number reader for the header value; the first value byte starts it afresh.
   always_comb begin
      nf_phase_src = (st == ST_AFTER_COLON) ? NUM_SKIP : nphase;
      nf_neg_src   = (st == ST_AFTER_COLON) ? 1'b0 : nneg;
      nf_acc_src   = (st == ST_AFTER_COLON) ? '0 : nacc;
      nf_wide      = ({4'd0, nf_acc_src} << 3) + ({4'd0, nf_acc_src} << 1)
                   + {{LW{1'b0}}, 4'(c - CH_ZERO)};
      nf_phase     = nf_phase_src;
      nf_neg       = nf_neg_src;
      nf_acc       = nf_acc_src;
      priority if ((nf_phase_src == NUM_SKIP) && is_space(c)) begin
      end else if ((nf_phase_src == NUM_SKIP) && ((c == CH_PLUS) || (c == CH_MINUS))) begin
         nf_neg   = (c == CH_MINUS);
         nf_phase = NUM_SIGN;
      end else if ((nf_phase_src != NUM_DONE) && is_digit(c)) begin
         nf_acc   = (nf_wide[LW+3:LW] != 4'd0) ? LEN_MASK : nf_wide[LW-1:0];
         nf_phase = NUM_DIGITS;
      end else begin
         nf_phase = NUM_DONE;
      end
   end

   assign body_count_inc = bcount + {{(LW-1){1'b0}}, 1'b1};

   always_comb begin
      state_in       = st;
      key_pos_in     = kpos;
      key_match_in   = kmatch;
      len_seen_in    = lseen;
      num_phase_in   = nphase;
      num_neg_in     = nneg;
      num_acc_in     = nacc;
      len_value_in   = lval;
      body_count_in  = bcount;
      rsp_tag_in     = TAG_NONE;
      rsp_first_in   = 1'b0;
      rsp_commit_in  = COMMIT_NONE;
      rsp_ignored_in = 1'b0;

      unique case (st)
         ST_START: begin
            if ((c == CH_CR) || (c == CH_LF) || is_blank(c)) begin
            end else if (is_upper(c)) begin
               rsp_tag_in   = TAG_METHOD;
               rsp_first_in = 1'b1;
               state_in     = ST_METHOD;
            end else begin
               state_in = ST_INVALID;
            end
         end
         ST_METHOD: begin
            if (is_upper(c)) rsp_tag_in = TAG_METHOD;
            else if (is_blank(c)) state_in = ST_BEFORE_URI;
            else state_in = ST_INVALID;
         end
         ST_BEFORE_URI: begin
            if (c == CH_SLASH) begin
               rsp_tag_in   = TAG_PATH;
               rsp_first_in = 1'b1;
               state_in     = ST_IN_URI;
            end else if (!is_blank(c)) begin
               state_in = ST_INVALID;
            end
         end
         ST_IN_URI: begin
            if (c == CH_QUESTION) state_in = ST_BEFORE_QKEY;
            else if (is_blank(c)) state_in = ST_BEFORE_PROTO;
            else rsp_tag_in = TAG_PATH;
         end
         ST_BEFORE_QKEY: begin
            if (is_blank(c) || (c == CH_CR) || (c == CH_LF)) begin
               state_in = ST_INVALID;
            end else begin
               rsp_tag_in   = TAG_QKEY;
               rsp_first_in = 1'b1;
               state_in     = ST_QKEY;
            end
         end
         ST_QKEY: begin
            if (c == CH_EQUALS) state_in = ST_BEFORE_QVAL;
            else if (is_blank(c)) state_in = ST_INVALID;
            else rsp_tag_in = TAG_QKEY;
         end
         ST_BEFORE_QVAL: begin
            if (is_blank(c) || (c == CH_CR) || (c == CH_LF)) begin
               state_in = ST_INVALID;
            end else begin
               rsp_tag_in   = TAG_QVAL;
               rsp_first_in = 1'b1;
               state_in     = ST_QVAL;
            end
         end
         ST_QVAL: begin
            if (c == CH_AMP) begin
               rsp_commit_in = COMMIT_QUERY;
               state_in      = ST_BEFORE_QKEY;
            end else if (is_blank(c)) begin
               rsp_commit_in = COMMIT_QUERY;
               state_in      = ST_BEFORE_PROTO;
            end else begin
               rsp_tag_in = TAG_QVAL;
            end
         end
         ST_BEFORE_PROTO: begin
            if (!is_blank(c)) begin
               rsp_tag_in   = TAG_PROTO;
               rsp_first_in = 1'b1;
               state_in     = ST_PROTO;
            end
         end
         ST_PROTO: begin
            if (c == CH_SLASH) state_in = ST_BEFORE_VER;
            else rsp_tag_in = TAG_PROTO;
         end
         ST_BEFORE_VER: begin
            if (is_digit(c)) begin
               rsp_tag_in   = TAG_VERSION;
               rsp_first_in = 1'b1;
               state_in     = ST_VER;
            end else begin
               state_in = ST_INVALID;
            end
         end
         ST_VER: begin
            if (c == CH_CR) begin
               state_in = ST_CR;
            end else if (c == CH_DOT) begin
               rsp_tag_in = TAG_VERSION;
               state_in   = ST_VER_DOT;
            end else if (is_digit(c)) begin
               rsp_tag_in = TAG_VERSION;
            end else begin
               state_in = ST_INVALID;
            end
         end
         ST_VER_DOT: begin
            if (is_digit(c)) begin
               rsp_tag_in = TAG_VERSION;
               state_in   = ST_VER;
            end else begin
               state_in = ST_INVALID;
            end
         end
         ST_HKEY: begin
            if (is_blank(c)) begin
               state_in = ST_BEFORE_COLON;
            end else if (c == CH_COLON) begin
               state_in = ST_AFTER_COLON;
            end else begin
               rsp_tag_in   = TAG_HKEY;
               key_pos_in   = kf_pos;
               key_match_in = kf_match;
            end
         end
         ST_BEFORE_COLON: begin
            if (c == CH_COLON) state_in = ST_AFTER_COLON;
            else if (!is_blank(c)) state_in = ST_INVALID;
         end
         ST_AFTER_COLON: begin
            if (!is_blank(c)) begin
               rsp_tag_in   = TAG_HVAL;
               rsp_first_in = 1'b1;
               state_in     = ST_HVAL;
               num_phase_in = nf_phase;
               num_neg_in   = nf_neg;
               num_acc_in   = nf_acc;
            end
         end
         ST_HVAL: begin
            if (c == CH_CR) begin
               rsp_commit_in = COMMIT_HEADER;
               state_in      = ST_CR;
               if (kmatch && (kpos == KEY_LEN) && !lseen) begin
                  len_seen_in  = 1'b1;
                  len_value_in = nneg ? '0 : nacc;
               end
            end else begin
               rsp_tag_in   = TAG_HVAL;
               num_phase_in = nf_phase;
               num_neg_in   = nf_neg;
               num_acc_in   = nf_acc;
            end
         end
         ST_CR: begin
            state_in = (c == CH_LF) ? ST_CRLF : ST_INVALID;
         end
         ST_CRLF: begin
            if (c == CH_CR) begin
               state_in = ST_CRLFCR;
            end else if (is_blank(c)) begin
               state_in = ST_INVALID;
            end else begin
               rsp_tag_in   = TAG_HKEY;
               rsp_first_in = 1'b1;
               state_in     = ST_HKEY;
               key_pos_in   = kf_pos;
               key_match_in = kf_match;
            end
         end
         ST_CRLFCR: begin
            if (c == CH_LF) begin
               state_in = (lseen && (lval != '0)) ? ST_BODY : ST_COMPLETE;
            end else begin
               state_in = ST_INVALID;
            end
         end
         ST_BODY: begin
            rsp_tag_in    = TAG_BODY;
            rsp_first_in  = (bcount == '0);
            body_count_in = body_count_inc;
            if (body_count_inc >= lval) state_in = ST_COMPLETE;
         end
         default: begin
            rsp_ignored_in = 1'b1;
         end
      endcase

      if (state_in == ST_COMPLETE) rsp_status_in = STATUS_COMPLETE;
      else if (state_in == ST_INVALID) rsp_status_in = STATUS_INVALID;
      else rsp_status_in = STATUS_PARSING;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
      if (req_ch.ready && req_ch.valid) begin
         in_byte_ff  <= req_ch.data_byte;
         in_start_ff <= req_ch.start_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_START;
         key_pos_ff    <= 4'd0;
         key_match_ff  <= 1'b0;
         len_seen_ff   <= 1'b0;
         num_phase_ff  <= NUM_SKIP;
         num_neg_ff    <= 1'b0;
         num_acc_ff    <= '0;
         len_value_ff  <= '0;
         body_count_ff <= '0;
      end else if (advance) begin
         state_ff      <= state_in;
         key_pos_ff    <= key_pos_in;
         key_match_ff  <= key_match_in;
         len_seen_ff   <= len_seen_in;
         num_phase_ff  <= num_phase_in;
         num_neg_ff    <= num_neg_in;
         num_acc_ff    <= num_acc_in;
         len_value_ff  <= len_value_in;
         body_count_ff <= body_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_byte_ff    <= in_byte_ff;
         rsp_tag_ff     <= rsp_tag_in;
         rsp_first_ff   <= rsp_first_in;
         rsp_commit_ff  <= rsp_commit_in;
         rsp_status_ff  <= rsp_status_in;
         rsp_ignored_ff <= rsp_ignored_in;
      end
   end

   // The length register only changes when a new result is loaded, so it can drive the port.
   assign len_ext             = {32'd0, len_value_ff};
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.echo_byte    = rsp_byte_ff;
   assign rsp_ch.field_tag    = rsp_tag_ff;
   assign rsp_ch.field_first  = rsp_first_ff;
   assign rsp_ch.pair_commit  = rsp_commit_ff;
   assign rsp_ch.parse_status = rsp_status_ff;
   assign rsp_ch.byte_ignored = rsp_ignored_ff;
   assign rsp_ch.body_length  = len_ext[31:0];

endmodule

// ----- src/hrbp_checker.sv -----
// Checker on the result port of the request parser, with its bind to the top level.
module hrbp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic [3:0] field_tag,
   input logic       field_first,
   input logic [1:0] pair_commit,
   input logic [1:0] parse_status,
   input logic       byte_ignored
);
   import hrbp_pkg::*;

   // An ignored byte belongs to no field and finishes no pair.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && byte_ignored |->
         field_tag == TAG_NONE && !field_first && pair_commit == COMMIT_NONE)
   else $error("ignored byte carries a field tag, first mark or commit");

   // Pairs are finished on separator bytes, which carry no tag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && pair_commit != COMMIT_NONE |-> field_tag == TAG_NONE)
   else $error("pair commit on a tagged byte");

   // The byte that makes a request invalid is not tagged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && parse_status == STATUS_INVALID |-> field_tag == TAG_NONE)
   else $error("tagged byte with invalid status");

   // A first-byte mark always belongs to a field.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && field_first |-> field_tag != TAG_NONE)
   else $error("first mark on an untagged byte");

   // No result is offered in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
   else $error("result offered straight after reset");

endmodule

bind http_request_byte_parser hrbp_checker u_hrbp_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .field_tag    (rsp_ch.field_tag),
   .field_first  (rsp_ch.field_first),
   .pair_commit  (rsp_ch.pair_commit),
   .parse_status (rsp_ch.parse_status),
   .byte_ignored (rsp_ch.byte_ignored)
);
